### rtl/mcm_pkg.sv
// ----------------------------------------------------------------------------
// Mirrored cartridge memory package
// Shared constants, register indexes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

  // Default storage and address geometry
  localparam int unsigned DEFAULT_MEM_DEPTH = 8192;
  localparam int unsigned DEFAULT_ADDR_BITS = 24;

  // Field widths of the stream items
  localparam int unsigned ADDRESS_W = 24;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 13;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ENABLE = 1'd1;

  localparam logic [CFG_DATA_W-1:0] MEM_SIZE_RST     = 14'd8192;
  localparam logic                  WRITE_ENABLE_RST = 1'b1;

  // Controller states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_MEM   = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

### rtl/mirrored_cartridge_memory_top.sv
// ----------------------------------------------------------------------------
// Mirrored cartridge memory
// Byte store behind a wide address; each access folds the address into the
// configured size one address bit per cycle, then reads or writes the store.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tuser: action; tdata: address, write_data
//  m_axis    out        m_axis_tvalid/tready       tdata: read_data, mapped_index
//  cfg       in         cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
//  The fold walks the address one bit per cycle from the top bit, stopping once
//  the residual falls below the remaining size, and is skipped when the size
//  is zero. A new item is accepted only once the last one has gone to the output register.
//  After reset the store is cleared one byte a cycle, with no item accepted;
//  configuration writes are taken during that pass.
//  A result waiting in the output register holds the next item in its last cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mirrored_cartridge_memory_top #(
  parameter int unsigned MEM_DEPTH = mcm_pkg::DEFAULT_MEM_DEPTH,
  parameter int unsigned ADDR_BITS = mcm_pkg::DEFAULT_ADDR_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  // Access items
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [31:0]                    s_axis_tdata,  // [23:0] address, [31:24] write_data
  input  wire logic                           s_axis_tuser,  // [0] action (0 read, 1 write)

  // Result items
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [23:0]                         m_axis_tdata,  // [7:0] read_data, [20:8] mapped_index

  // Configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [mcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mcm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned SW    = mcm_pkg::CFG_DATA_W;
  localparam logic [ADDR_BITS-1:0] TOP_BIT = ADDR_BITS'(1) << (ADDR_BITS - 1);
  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(MEM_DEPTH - 1);

  // Configuration registers
  logic [SW-1:0] mem_size_q;
  logic          write_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q     <= mcm_pkg::MEM_SIZE_RST;
      write_enable_q <= mcm_pkg::WRITE_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcm_pkg::REG_MEM_SIZE:     mem_size_q     <= cfg_wdata_i;
        mcm_pkg::REG_WRITE_ENABLE: write_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control state
  mcm_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             out_valid_q, out_valid_d;

  // Fold datapath
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [ADDR_BITS-1:0] bit_q, bit_d;
  logic [SW-1:0]        size_q, size_d;
  logic [SW-1:0]        base_q, base_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 write_q, write_d;
  logic                 empty_q, empty_d;
  logic [mcm_pkg::BYTE_W-1:0] wbyte_q, wbyte_d;

  // Output register
  logic [mcm_pkg::BYTE_W-1:0]  out_rdata_q, out_rdata_d;
  logic [mcm_pkg::INDEX_W-1:0] out_index_q, out_index_d;

  // Memory
  logic [mcm_pkg::BYTE_W-1:0] mem [MEM_DEPTH];
  logic [mcm_pkg::BYTE_W-1:0] rdata_q;
  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_addr;
  logic [mcm_pkg::BYTE_W-1:0] mem_wdata;

  // Helpers
  logic        accept;
  logic        out_free;
  logic [31:0] addr_w, size_w, bit_w, sum_w, cfg_size_w;
  logic [SW-1:0] size_eff;
  logic        fold_done;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign addr_w     = 32'(addr_q);
  assign size_w     = 32'(size_q);
  assign bit_w      = 32'(bit_q);
  assign sum_w      = 32'(base_q) + addr_w;
  assign cfg_size_w = 32'(mem_size_q);
  assign fold_done  = (addr_w < size_w) || (bit_q == '0);

  // Saturate the configured size to the store depth
  always_comb begin
    if (cfg_size_w > 32'(MEM_DEPTH)) begin
      size_eff = SW'(MEM_DEPTH);
    end else begin
      size_eff = mem_size_q;
    end
  end

  // Next-state and datapath logic
  always_comb begin
    logic [31:0] in_addr;
    in_addr     = 32'(s_axis_tdata[mcm_pkg::ADDRESS_W-1:0]);
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    size_d      = size_q;
    base_d      = base_q;
    idx_d       = idx_q;
    write_d     = write_q;
    empty_d     = empty_q;
    wbyte_d     = wbyte_q;
    out_rdata_d = out_rdata_q;
    out_index_d = out_index_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = idx_q;
    mem_wdata   = wbyte_q;

    // Drop a result once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mcm_pkg::ST_CLEAR: begin
        // Zero one byte per cycle
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == LAST_IDX) begin
          state_d = mcm_pkg::ST_IDLE;
        end
      end
      mcm_pkg::ST_IDLE: begin
        if (accept) begin
          addr_d  = in_addr[ADDR_BITS-1:0];
          bit_d   = TOP_BIT;
          size_d  = size_eff;
          base_d  = '0;
          write_d = s_axis_tuser;
          wbyte_d = s_axis_tdata[mcm_pkg::ADDRESS_W +: mcm_pkg::BYTE_W];
          idx_d   = '0;
          if (size_eff == '0) begin
            empty_d = 1'b1;
            state_d = mcm_pkg::ST_MEM;
          end else begin
            empty_d = 1'b0;
            state_d = mcm_pkg::ST_FOLD;
          end
        end
      end
      mcm_pkg::ST_FOLD: begin
        if (fold_done) begin
          // Base plus residual gives the store index
          if (sum_w < 32'(MEM_DEPTH)) begin
            idx_d = IDX_W'(sum_w);
          end else begin
            idx_d = '0;
          end
          state_d = mcm_pkg::ST_MEM;
        end else begin
          // Remove the current bit if set; move it to the base if it fits
          if ((addr_q & bit_q) != '0) begin
            addr_d = addr_q & ~bit_q;
            if (size_w > bit_w) begin
              size_d = size_q - SW'(bit_w);
              base_d = base_q + SW'(bit_w);
            end
          end
          bit_d = bit_q >> 1;
        end
      end
      mcm_pkg::ST_MEM: begin
        if (!empty_q) begin
          mem_re = !write_q;
          mem_we = write_q && write_enable_q;
        end
        state_d = mcm_pkg::ST_LOAD;
      end
      mcm_pkg::ST_LOAD: begin
        // Hand the result to the output register when it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rdata_d = (write_q || empty_q) ? '0 : rdata_q;
          out_index_d = mcm_pkg::INDEX_W'(32'(idx_q));
          state_d     = mcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcm_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    bit_q       <= bit_d;
    size_q      <= size_d;
    base_q      <= base_d;
    idx_q       <= idx_d;
    write_q     <= write_d;
    empty_q     <= empty_d;
    wbyte_q     <= wbyte_d;
    out_rdata_q <= out_rdata_d;
    out_index_q <= out_index_d;
  end

  // Byte store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Ports
  assign s_axis_tready = (state_q == mcm_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_index_q, out_rdata_q};

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mirrored cartridge memory testbench
// Drives access items and size / write-protect settings into the block and
// checks each result against a behavioral model of the address fold and the
// byte store (typed rows: the table). A directed table, then random phases.
// ----------------------------------------------------------------------------

module tb_top;
  import mcm_pkg::*;

  localparam int unsigned STORE_DEPTH  = DEFAULT_MEM_DEPTH;
  localparam int          RANDOM_ITEMS = 1030;
  localparam int          CALM_TAIL    = 80;
  // Clear pass plus ~1050 items with their folding, source gaps and sink
  // stalls, taken several times
  localparam int          CYCLE_LIMIT  = 400000;

  typedef enum logic [0:0] {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } access_e;

  typedef enum logic [0:0] {
    ROW_ACCESS = 1'b0,
    ROW_CONFIG = 1'b1
  } row_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  rdata;
    logic [INDEX_W-1:0] index;
  } result_t;

  typedef struct packed {
    row_e                  kind;
    access_e               act;
    logic [ADDRESS_W-1:0]  addr;
    logic [BYTE_W-1:0]     wdata;
    logic [CFG_DATA_W-1:0] size;
    logic                  wen;
    logic                  typed;
    logic [BYTE_W-1:0]     want_rdata;
    logic [INDEX_W-1:0]    want_index;
  } stim_row_t;

  // Directed rows: reset contents, address extremes, empty memory, size
  // saturation, tiny and odd sizes, write protection
  localparam stim_row_t DIRECTED [28] = '{
    '{ROW_ACCESS, ACT_READ,  24'h000000, 8'h00, 14'd0,     1'b0, 1'b1, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'hFFFFFF, 8'h00, 14'd0,     1'b0, 1'b1, 8'h00, 13'd8191},
    '{ROW_ACCESS, ACT_WRITE, 24'h001234, 8'hFF, 14'd0,     1'b0, 1'b1, 8'h00, 13'h1234},
    '{ROW_ACCESS, ACT_READ,  24'h7F1234, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_WRITE, 24'hFFFFFF, 8'hA5, 14'd0,     1'b0, 1'b1, 8'h00, 13'd8191},
    '{ROW_ACCESS, ACT_READ,  24'h001FFF, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_CONFIG, ACT_READ,  24'h000000, 8'h00, 14'd0,     1'b1, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h001234, 8'h00, 14'd0,     1'b0, 1'b1, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_WRITE, 24'hFFFFFF, 8'h5A, 14'd0,     1'b0, 1'b1, 8'h00, 13'd0},
    '{ROW_CONFIG, ACT_READ,  24'h000000, 8'h00, 14'd16383, 1'b1, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'hFFFFFF, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h800000, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_CONFIG, ACT_READ,  24'h000000, 8'h00, 14'd1,     1'b1, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'hFFFFFF, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_WRITE, 24'h123456, 8'h3C, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_CONFIG, ACT_READ,  24'h000000, 8'h00, 14'd3,     1'b1, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h000002, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h000003, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'hFFFFFF, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_CONFIG, ACT_READ,  24'h000000, 8'h00, 14'd6000,  1'b1, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h001770, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h001FFF, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h800000, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_CONFIG, ACT_READ,  24'h000000, 8'h00, 14'd6000,  1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_WRITE, 24'h001234, 8'h77, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h001234, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0},
    '{ROW_CONFIG, ACT_READ,  24'h000000, 8'h00, 14'd8192,  1'b1, 1'b0, 8'h00, 13'd0},
    '{ROW_ACCESS, ACT_READ,  24'h001234, 8'h00, 14'd0,     1'b0, 1'b0, 8'h00, 13'd0}
  };

  // DUT signals
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;  // [23:0] address, [31:24] write_data
  logic                  s_axis_tuser  = 1'b0; // [0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [23:0]           m_axis_tdata;         // [7:0] read_data, [20:8] mapped_index
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_MEM_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // Model state
  logic [BYTE_W-1:0]     shadow_store [STORE_DEPTH];
  logic [CFG_DATA_W-1:0] shadow_size = MEM_SIZE_RST;
  logic                  shadow_wen  = WRITE_ENABLE_RST;
  result_t               pending_results [$];

  // Run bookkeeping
  logic [ADDRESS_W-1:0]  recent_addr [16];
  int                    recent_fill    = 0;
  int                    fault_count    = 0;
  int                    checked_count  = 0;
  int                    read_count     = 0;
  int                    write_count    = 0;
  int                    config_count   = 0;
  int                    cycle_count    = 0;
  int                    sink_stall_pct = 0;
  bit                    calm           = 1'b0;

  mirrored_cartridge_memory_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Size in use, saturated at the store depth
  function automatic int unsigned live_span();
    return (shadow_size > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_size);
  endfunction

  // Fold an address into [0, span): walk down from the top bit, strip set
  // bits until the address fits; a stripped bit below the remaining size
  // moves into the base and out of the size
  function automatic logic [INDEX_W-1:0] fold_into(logic [ADDRESS_W-1:0] addr,
                                                   int unsigned span);
    int unsigned rest;
    int unsigned room;
    int unsigned base;
    int unsigned bitv;
    rest = addr;
    room = span;
    base = 0;
    for (int b = ADDRESS_W - 1; b >= 0; b--) begin
      if (rest < room) break;
      bitv = 32'd1 << b;
      if ((rest & bitv) != 0) begin
        rest -= bitv;
        if (room > bitv) begin
          room -= bitv;
          base += bitv;
        end
      end
    end
    return (base + rest >= STORE_DEPTH) ? '0 : INDEX_W'(base + rest);
  endfunction

  // Work out one access against the model store and apply its write
  function automatic result_t predict_access(access_e act, logic [ADDRESS_W-1:0] addr,
                                             logic [BYTE_W-1:0] wdata);
    result_t     res;
    int unsigned span;
    span = live_span();
    res  = '0;
    if (span != 0) begin
      res.index = fold_into(addr, span);
      if (act == ACT_READ) begin
        res.rdata = shadow_store[res.index];
      end else if (shadow_wen) begin
        shadow_store[res.index] = wdata;
      end
    end
    return res;
  endfunction

  // Random address: full range, shifted down, near the live size, around powers of two,
  // or back onto recently written addresses and their mirrors
  function automatic logic [ADDRESS_W-1:0] pick_address();
    int unsigned span;
    int unsigned k;
    logic [ADDRESS_W-1:0] a;
    span = live_span();
    case ($urandom_range(0, 5))
      0: a = ADDRESS_W'($urandom());
      1: a = (span == 0) ? ADDRESS_W'($urandom()) : ADDRESS_W'($urandom_range(0, 2 * span - 1));
      2: begin
        k = $urandom_range(0, ADDRESS_W - 1);
        a = (ADDRESS_W'(1) << k) - ADDRESS_W'(1) + ADDRESS_W'($urandom_range(0, 2));
      end
      3: a = ADDRESS_W'($urandom() >> $urandom_range(0, 31));
      4: a = (recent_fill == 0) ? ADDRESS_W'($urandom())
                                : recent_addr[$urandom_range(0, recent_fill - 1)];
      default: begin
        a = (recent_fill == 0) ? '0 : recent_addr[$urandom_range(0, recent_fill - 1)];
        a = a ^ {11'($urandom()), 13'h0};
      end
    endcase
    return a;
  endfunction

  // Offer one item, hold it until accepted, record what it must produce
  task automatic send_access(access_e act, logic [ADDRESS_W-1:0] addr,
                             logic [BYTE_W-1:0] wdata, logic typed, result_t typed_res);
    result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, addr};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_access(act, addr, wdata);
    pending_results.push_back(typed ? typed_res : predicted);
    if (act == ACT_WRITE) begin
      write_count++;
      recent_addr[recent_fill % 16] = addr;
      if (recent_fill < 16) recent_fill++;
    end else begin
      read_count++;
    end
  endtask

  // Drop valid for a burst of cycles
  task automatic rest_source(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold the source until every result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Write both registers once the block is idle
  task automatic apply_config(logic [CFG_DATA_W-1:0] size, logic wen);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MEM_SIZE;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_idx_i   <= REG_WRITE_ENABLE;
    cfg_wdata_i <= CFG_DATA_W'(wen);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_size = size;
    shadow_wen  = wen;
    config_count++;
    @(posedge clk_i);
  endtask

  task automatic log_fault(string what, result_t want, result_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("t=%0t %s: expected rdata=%02h index=%0d, got rdata=%02h index=%0d",
               $realtime, what, want.rdata, want.index, got.rdata, got.index);
    end
  endtask

  // Check each result item against the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.rdata = m_axis_tdata[7:0];
      got.index = m_axis_tdata[20:8];
      checked_count++;
      if (pending_results.size() == 0) begin
        log_fault("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.rdata !== want.rdata) log_fault("read_data", want, got);
        if (got.index !== want.index) log_fault("mapped_index", want, got);
      end
    end
  end

  // Stall the result side in random bursts
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(1, 16);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Stimulus
  initial begin : stimulus
    int               sent;
    int               phase;
    int               phase_len;
    int               gap_pct;
    logic [CFG_DATA_W-1:0] size;
    logic             wen;
    access_e          act;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CONFIG) begin
        apply_config(DIRECTED[r].size, DIRECTED[r].wen);
      end else begin
        send_access(DIRECTED[r].act, DIRECTED[r].addr, DIRECTED[r].wdata,
                    DIRECTED[r].typed, '{DIRECTED[r].want_rdata, DIRECTED[r].want_index});
      end
    end

    // Random phases, each under its own size and protection setting
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wen = ($urandom_range(0, 4) != 0);
      case (phase)
        0: size = 14'd8192;
        1: size = 14'd16383;
        2: size = 14'd0;
        3: size = 14'd1;
        4: begin
          size = 14'd8192;
          wen  = 1'b0;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: size = 14'd0;
            1: size = 14'd1;
            2: size = 14'd16383;
            3: size = 14'd8192;
            4: size = 14'd1 << $urandom_range(0, 12);
            5: size = 14'($urandom_range(8193, 16383));
            default: size = 14'($urandom_range(2, 8191));
          endcase
        end
      endcase
      apply_config(size, wen);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: sink_stall_pct = 0;
        1: sink_stall_pct = 15;
        default: sink_stall_pct = 40;
      endcase
      phase_len = $urandom_range(30, 90);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        calm = (RANDOM_ITEMS - sent) <= CALM_TAIL;
        act  = ($urandom_range(0, 99) < 45) ? ACT_WRITE : ACT_READ;
        send_access(act, pick_address(), BYTE_W'($urandom()), 1'b0, '0);
        sent++;
        if (!calm && $urandom_range(0, 63) == 0) begin
          settle();
        end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
          rest_source($urandom_range(1, 16));
        end
      end
      phase++;
    end

    // Drain, then let a full fold's worth of cycles pass
    settle();
    repeat (40) @(posedge clk_i);
    fault_count += pending_results.size();

    $display("Covered %0d accesses (%0d reads, %0d writes) under %0d register settings,",
             read_count + write_count, read_count, write_count, config_count);
    $display("including empty, saturated, odd and write-protected sizes; %0d results checked.",
             checked_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fault_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
